@@ hw/rtl/rsi_pkg.sv @@
//------------------------------------------------------------------------------
// Ray-sphere intersection package
// Result record and status codes shared by the intersection pipeline.
//------------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

   // Width of one coordinate port and of the radius port.
   localparam int FIELD_WIDTH  = 32;
   localparam int RADIUS_WIDTH = 31;

   // Result status codes.
   localparam logic [1:0] STATUS_HIT      = 2'd0;
   localparam logic [1:0] STATUS_MISS     = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DIR = 2'd2;

   typedef struct packed {
      logic [1:0]             status;
      logic [FIELD_WIDTH-1:0] hit_distance;
      logic                   saturated;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/rsi_fifo.sv @@
//------------------------------------------------------------------------------
// Small synchronous FIFO
// Register-based queue with push/full and pop/empty handshakes.
//------------------------------------------------------------------------------
`default_nettype none

module rsi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNTW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNTW'(do_push) - CNTW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rsi_front.sv @@
//------------------------------------------------------------------------------
// Ray-sphere front end
// Accepts ray-sphere pairs, forms center minus origin, flags a zero direction
// and queues the classified item for the arithmetic back end.
//------------------------------------------------------------------------------
`default_nettype none

module rsi_front #(
   parameter int CW = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic [2:0][rsi_pkg::FIELD_WIDTH-1:0]   origin,
   input  wire logic [2:0][rsi_pkg::FIELD_WIDTH-1:0]   dir,
   input  wire logic [2:0][rsi_pkg::FIELD_WIDTH-1:0]   center,
   input  wire logic [rsi_pkg::RADIUS_WIDTH-1:0]       radius,
   output logic                                        item_valid,
   input  wire logic                                   item_pop,
   output logic [1+(CW-1)+3*CW+3*(CW+1)-1:0]           item_data
);

   localparam int IW = 1 + (CW - 1) + 3 * CW + 3 * (CW + 1);

   logic [IW-1:0]      packed_item;
   logic signed [CW:0] oc [3];
   logic               zero_dir;
   logic               queue_empty;

   // Item layout, low to high: oc x/y/z, dir x/y/z, radius, zero-direction flag.
   always_comb begin
      zero_dir    = 1'b1;
      packed_item = '0;
      for (int i = 0; i < 3; i++) begin
         oc[i] = (CW + 1)'(signed'(center[i][CW-1:0]))
               - (CW + 1)'(signed'(origin[i][CW-1:0]));
         if (dir[i][CW-1:0] != '0) begin
            zero_dir = 1'b0;
         end
         packed_item[i*(CW+1) +: CW+1]     = oc[i];
         packed_item[3*(CW+1)+i*CW +: CW]  = dir[i][CW-1:0];
      end
      packed_item[3*(CW+1)+3*CW +: CW-1] = radius[CW-2:0];
      packed_item[IW-1]                  = zero_dir;
   end

   rsi_fifo #(
      .WIDTH(IW),
      .DEPTH(2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(packed_item),
      .full     (req_full),
      .pop      (item_pop),
      .pop_data (item_data),
      .empty    (queue_empty)
   );

   assign item_valid = !queue_empty;

endmodule

`default_nettype wire

@@ hw/rtl/rsi_sqrt.sv @@
//------------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, restoring digit recurrence, with a side tag.
//------------------------------------------------------------------------------
`default_nettype none

module rsi_sqrt #(
   parameter int RW   = 64,
   parameter int TAGW = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [2*RW-1:0]   in_radicand,
   input  wire logic [TAGW-1:0]   in_tag,
   output logic                   out_valid,
   output logic [RW-1:0]          out_root,
   output logic [TAGW-1:0]        out_tag
);

   logic            valid_ff [0:RW-1];
   logic [RW:0]     rem_ff   [0:RW-1];
   logic [RW-1:0]   root_ff  [0:RW-1];
   logic [2*RW-1:0] rad_ff   [0:RW-1];
   logic [TAGW-1:0] tag_ff   [0:RW-1];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic            valid_prev;
      logic [RW:0]     rem_prev, rem_in;
      logic [RW-1:0]   root_prev, root_in;
      logic [2*RW-1:0] rad_prev, rad_in;
      logic [TAGW-1:0] tag_prev;
      logic [RW+2:0]   rem_shift, trial, diff;
      logic            fits;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_radicand;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      assign rem_shift = {rem_prev, rad_prev[2*RW-1 -: 2]};
      assign trial     = {1'b0, root_prev, 2'b01};
      assign fits      = (rem_shift >= trial);
      assign diff      = rem_shift - trial;
      assign rem_in    = fits ? diff[RW:0] : rem_shift[RW:0];
      assign root_in   = {root_prev[RW-2:0], fits};
      assign rad_in    = {rad_prev[2*RW-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
            tag_ff[k]  <= tag_prev;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_tag   = tag_ff[RW-1];

endmodule

`default_nettype wire

@@ hw/rtl/rsi_div.sv @@
//------------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring long division, one quotient bit per stage, with a side tag.
//------------------------------------------------------------------------------
`default_nettype none

module rsi_div #(
   parameter int NW   = 82,
   parameter int DVW  = 64,
   parameter int TAGW = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [NW-1:0]    in_dividend,
   input  wire logic [DVW-1:0]   in_divisor,
   input  wire logic [TAGW-1:0]  in_tag,
   output logic                  out_valid,
   output logic [NW-1:0]         out_quotient,
   output logic                  out_rem_nonzero,
   output logic [TAGW-1:0]       out_tag
);

   logic            valid_ff [0:NW-1];
   logic [DVW-1:0]  rem_ff   [0:NW-1];
   logic [NW-1:0]   dvd_ff   [0:NW-1];
   logic [NW-1:0]   quo_ff   [0:NW-1];
   logic [DVW-1:0]  dvs_ff   [0:NW-1];
   logic [TAGW-1:0] tag_ff   [0:NW-1];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic            valid_prev;
      logic [DVW-1:0]  rem_prev, rem_in, dvs_prev;
      logic [NW-1:0]   dvd_prev, quo_prev;
      logic [TAGW-1:0] tag_prev;
      logic [DVW:0]    rem_shift, diff;
      logic            fits;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign dvd_prev   = in_dividend;
         assign quo_prev   = '0;
         assign dvs_prev   = in_divisor;
         assign tag_prev   = in_tag;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign dvd_prev   = dvd_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign dvs_prev   = dvs_ff[k-1];
         assign tag_prev   = tag_ff[k-1];
      end

      assign rem_shift = {rem_prev, dvd_prev[NW-1]};
      assign fits      = (rem_shift >= {1'b0, dvs_prev});
      assign diff      = rem_shift - {1'b0, dvs_prev};
      assign rem_in    = fits ? diff[DVW-1:0] : rem_shift[DVW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            dvd_ff[k] <= {dvd_prev[NW-2:0], 1'b0};
            quo_ff[k] <= {quo_prev[NW-2:0], fits};
            dvs_ff[k] <= dvs_prev;
            tag_ff[k] <= tag_prev;
         end
      end
   end

   assign out_valid       = valid_ff[NW-1];
   assign out_quotient    = quo_ff[NW-1];
   assign out_rem_nonzero = (rem_ff[NW-1] != '0);
   assign out_tag         = tag_ff[NW-1];

endmodule

`default_nettype wire

@@ hw/rtl/rsi_back.sv @@
//------------------------------------------------------------------------------
// Ray-sphere back end
// Exact quadratic terms, discriminant, square root, division and clamping.
//------------------------------------------------------------------------------
`default_nettype none

module rsi_back #(
   parameter int CW = 32,
   parameter int FB = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 en,
   input  wire logic                                 in_valid,
   input  wire logic [1+(CW-1)+3*CW+3*(CW+1)-1:0]    in_data,
   output logic                                      out_valid,
   output rsi_pkg::result_type                       out_result
);

   localparam int IW  = 1 + (CW - 1) + 3 * CW + 3 * (CW + 1);
   localparam int AW  = 2 * CW;          // a = d.d, unsigned
   localparam int HW  = 2 * CW + 2;      // h = d.oc, signed
   localparam int CDW = 2 * CW + 3;      // c = oc.oc - r^2, signed
   localparam int DW  = 4 * CW + 4;      // discriminant, signed
   localparam int SW  = 2 * CW;          // square root bits
   localparam int QW  = HW + FB;         // dividend and quotient bits
   localparam int STW = 2 + HW + AW;     // tag through the square root
   localparam int FW  = rsi_pkg::FIELD_WIDTH;
   localparam logic [QW:0] HALF     = (QW + 1)'(1) << (CW - 1);
   localparam logic [QW:0] MAX_POS  = HALF - 1'b1;

   // Unpack.
   logic signed [CW-1:0] d  [3];
   logic signed [CW:0]   oc [3];
   logic [CW-2:0]        rad;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         oc[i] = in_data[i*(CW+1) +: CW+1];
         d[i]  = in_data[3*(CW+1)+i*CW +: CW];
      end
      rad = in_data[3*(CW+1)+3*CW +: CW-1];
   end

   // Stage 1: products.
   logic                  s1_valid_ff, s1_zero_ff;
   logic signed [2*CW-1:0] dd_ff  [3];
   logic signed [2*CW:0]   doc_ff [3];
   logic signed [2*CW+1:0] oo_ff  [3];
   logic [2*CW-3:0]        rr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dd_ff[i]  <= (2*CW)'(d[i]) * (2*CW)'(d[i]);
            doc_ff[i] <= (2*CW+1)'(d[i]) * (2*CW+1)'(oc[i]);
            oo_ff[i]  <= (2*CW+2)'(oc[i]) * (2*CW+2)'(oc[i]);
         end
         rr_ff      <= (2*CW-2)'(rad) * (2*CW-2)'(rad);
         s1_zero_ff <= in_data[IW-1];
      end
   end

   // Stage 2: sums.
   logic                  s2_valid_ff, s2_zero_ff;
   logic [AW-1:0]         a2_ff;
   logic signed [HW-1:0]  h2_ff;
   logic signed [CDW-1:0] c2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a2_ff <= AW'(dd_ff[0]) + AW'(dd_ff[1]) + AW'(dd_ff[2]);
         h2_ff <= HW'(doc_ff[0]) + HW'(doc_ff[1]) + HW'(doc_ff[2]);
         c2_ff <= CDW'(oo_ff[0]) + CDW'(oo_ff[1]) + CDW'(oo_ff[2])
                - signed'(CDW'(rr_ff));
         s2_zero_ff <= s1_zero_ff;
      end
   end

   // Stage 3: a*c and h*h from word-sized partial products. Each operand is
   // split into an unsigned low word and a high part, signed for c and h, unsigned for a.
   logic                   s3_valid_ff, s3_zero_ff;
   logic [AW-1:0]          a3_ff;
   logic signed [HW-1:0]   h3_ff;
   logic [2*CW-1:0]        ac_ll_ff, ac_hl_ff, hh_ll_ff;
   logic signed [2*CW+3:0] ac_lh_ff, ac_hh_ff, hh_hh_ff;
   logic signed [2*CW+2:0] hh_lh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac_ll_ff   <= (2*CW)'(a2_ff[CW-1:0]) * (2*CW)'(c2_ff[CW-1:0]);
         ac_hl_ff   <= (2*CW)'(a2_ff[AW-1:CW]) * (2*CW)'(c2_ff[CW-1:0]);
         ac_lh_ff   <= (2*CW+4)'(signed'({1'b0, a2_ff[CW-1:0]}))
                     * (2*CW+4)'(signed'(c2_ff[CDW-1:CW]));
         ac_hh_ff   <= (2*CW+4)'(signed'({1'b0, a2_ff[AW-1:CW]}))
                     * (2*CW+4)'(signed'(c2_ff[CDW-1:CW]));
         hh_ll_ff   <= (2*CW)'(h2_ff[CW-1:0]) * (2*CW)'(h2_ff[CW-1:0]);
         hh_lh_ff   <= (2*CW+3)'(signed'({1'b0, h2_ff[CW-1:0]}))
                     * (2*CW+3)'(signed'(h2_ff[HW-1:CW]));
         hh_hh_ff   <= (2*CW+4)'(signed'(h2_ff[HW-1:CW]))
                     * (2*CW+4)'(signed'(h2_ff[HW-1:CW]));
         a3_ff      <= a2_ff;
         h3_ff      <= h2_ff;
         s3_zero_ff <= s2_zero_ff;
      end
   end

   // Stage 4: discriminant h^2 - a*c.
   logic                 s4_valid_ff, s4_zero_ff;
   logic [AW-1:0]        a4_ff;
   logic signed [HW-1:0] h4_ff;
   logic signed [DW-1:0] disc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         disc_ff <= DW'(hh_ll_ff) + (DW'(hh_lh_ff) <<< (CW + 1))
                  + (DW'(hh_hh_ff) <<< (2 * CW))
                  - DW'(ac_ll_ff) - (DW'(ac_lh_ff) <<< CW) - (DW'(ac_hl_ff) <<< CW)
                  - (DW'(ac_hh_ff) <<< (2 * CW));
         a4_ff      <= a3_ff;
         h4_ff      <= h3_ff;
         s4_zero_ff <= s3_zero_ff;
      end
   end

   // Classification and square root.
   logic [1:0]      status4;
   logic [2*SW-1:0] radicand;
   logic            sq_valid;
   logic [SW-1:0]   sq_root;
   logic [STW-1:0]  sq_tag;

   always_comb begin
      if (s4_zero_ff) begin
         status4 = rsi_pkg::STATUS_ZERO_DIR;
      end else if (disc_ff[DW-1]) begin
         status4 = rsi_pkg::STATUS_MISS;
      end else begin
         status4 = rsi_pkg::STATUS_HIT;
      end
      radicand = (status4 == rsi_pkg::STATUS_HIT) ? disc_ff[2*SW-1:0] : '0;
   end

   rsi_sqrt #(
      .RW  (SW),
      .TAGW(STW)
   ) u_sqrt (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (s4_valid_ff),
      .in_radicand(radicand),
      .in_tag     ({status4, h4_ff, a4_ff}),
      .out_valid  (sq_valid),
      .out_root   (sq_root),
      .out_tag    (sq_tag)
   );

   // Stage 5: numerator h - sqrt, split into sign and magnitude.
   logic signed [HW-1:0] t_h;
   logic signed [HW:0]   num, num_abs;
   logic                 s5_valid_ff, s5_neg_ff;
   logic [1:0]           s5_status_ff;
   logic [AW-1:0]        a5_ff;
   logic [HW-1:0]        abs5_ff;

   assign t_h     = sq_tag[AW +: HW];
   assign num     = (HW + 1)'(t_h) - signed'((HW + 1)'(sq_root));
   assign num_abs = num[HW] ? -num : num;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         abs5_ff      <= num_abs[HW-1:0];
         s5_neg_ff    <= num[HW];
         a5_ff        <= sq_tag[AW-1:0];
         s5_status_ff <= sq_tag[STW-1 -: 2];
      end
   end

   // Division of |h - s| * 2^FB by a.
   logic          dv_valid, dv_rem_nz;
   logic [QW-1:0] dv_quo;
   logic [2:0]    dv_tag;

   rsi_div #(
      .NW  (QW),
      .DVW (AW),
      .TAGW(3)
   ) u_div (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (s5_valid_ff),
      .in_dividend    ({abs5_ff, FB'(0)}),
      .in_divisor     (a5_ff),
      .in_tag         ({s5_status_ff, s5_neg_ff}),
      .out_valid      (dv_valid),
      .out_quotient   (dv_quo),
      .out_rem_nonzero(dv_rem_nz),
      .out_tag        (dv_tag)
   );

   // Floor toward minus infinity, then clamp to the signed coordinate range.
   logic          f_neg, f_sat;
   logic [QW:0]   qf;
   logic [CW-1:0] t_val;

   always_comb begin
      f_neg = dv_tag[0];
      qf    = {1'b0, dv_quo} + (QW + 1)'(f_neg && dv_rem_nz);
      f_sat = f_neg ? (qf > HALF) : (qf > MAX_POS);
      if (f_sat) begin
         t_val = f_neg ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         t_val = f_neg ? -qf[CW-1:0] : qf[CW-1:0];
      end
      out_result.status = dv_tag[2:1];
      if (dv_tag[2:1] == rsi_pkg::STATUS_HIT) begin
         out_result.hit_distance = FW'(signed'(t_val));
         out_result.saturated    = f_sat;
      end else begin
         out_result.hit_distance = '0;
         out_result.saturated    = 1'b0;
      end
   end

   assign out_valid = dv_valid;

endmodule

`default_nettype wire

@@ hw/rtl/ray_sphere_intersect.sv @@
//------------------------------------------------------------------------------
// Ray-sphere intersection engine
// Nearest hit distance of a ray against a sphere in signed fixed point.
//------------------------------------------------------------------------------
// Usage: the ray generator writes one ray-sphere pair per transfer on the req_
// queue port (push while full is low). Results come out in order on the rsp_
// queue port: a result waits on the rsp_ ports while rsp_empty is low and is
// taken by raising rsp_pop. Each result holds a status (hit, miss, or zero
// direction), the nearer root t in the input format, and a flag telling that t
// was clamped to the coordinate range.
// Throughput is one pair per cycle while the output queue has room. The path
// runs through the bit-per-stage square root (2*COORD_WIDTH stages) and
// the bit-per-stage divider (2*COORD_WIDTH + 2 + FRAC_BITS stages).
// Reset empties both queues and all pipeline valid bits; no pass is needed.
// When the receiver stalls, the output queue fills and the whole arithmetic
// pipeline freezes in place; the input queue then fills and req_full rises.
// The front end keeps accepting into its queue while the back end is stalled.
//------------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   output logic                                      req_full,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_origin_x,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_origin_y,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_origin_z,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_dir_x,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_dir_y,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_dir_z,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_center_x,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_center_y,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_center_z,
   input  wire logic [rsi_pkg::RADIUS_WIDTH-1:0]     req_sphere_radius,
   output logic                                      rsp_empty,
   input  wire logic                                 rsp_pop,
   output logic [1:0]                                rsp_status,
   output logic signed [rsi_pkg::FIELD_WIDTH-1:0]    rsp_hit_distance,
   output logic                                      rsp_saturated
);

   localparam int CW = COORD_WIDTH;
   localparam int IW = 1 + (CW - 1) + 3 * CW + 3 * (CW + 1);
   localparam int RW = $bits(rsi_pkg::result_type);

   logic                 item_valid;
   logic [IW-1:0]        item_data;
   logic                 back_en;
   logic                 back_valid;
   rsi_pkg::result_type  back_result;
   logic                 outq_full;
   logic                 outq_push;
   logic [RW-1:0]        outq_data;
   rsi_pkg::result_type  rsp_result;

   // Front end: operand setup and the queue toward the back end.
   rsi_front #(
      .CW(CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .origin    ({req_origin_z, req_origin_y, req_origin_x}),
      .dir       ({req_dir_z, req_dir_y, req_dir_x}),
      .center    ({req_center_z, req_center_y, req_center_x}),
      .radius    (req_sphere_radius),
      .item_valid(item_valid),
      .item_pop  (back_en),
      .item_data (item_data)
   );

   // The back end advances as a whole whenever the output queue has room, and
   // takes a new item from the front queue on every such cycle in which one waits.
   assign back_en = !outq_full;

   rsi_back #(
      .CW(CW),
      .FB(FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (item_valid),
      .in_data   (item_data),
      .out_valid (back_valid),
      .out_result(back_result)
   );

   assign outq_push = back_en && back_valid;

   // Output queue decouples the receiver from the pipeline.
   rsi_fifo #(
      .WIDTH(RW),
      .DEPTH(2)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (outq_push),
      .push_data(back_result),
      .full     (outq_full),
      .pop      (rsp_pop),
      .pop_data (outq_data),
      .empty    (rsp_empty)
   );

   assign rsp_result       = outq_data;
   assign rsp_status       = rsp_result.status;
   assign rsp_hit_distance = rsp_result.hit_distance;
   assign rsp_saturated    = rsp_result.saturated;

`ifndef SYNTHESIS
   // A miss or a zero direction carries no distance and no clamp flag.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != rsi_pkg::STATUS_HIT)
         |-> (rsp_hit_distance == '0 && !rsp_saturated))
      else $error("non-hit result carries a distance or clamp flag");

   // A clamped distance is one of the two range bounds, sign-extended.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_saturated)
         |-> (rsp_hit_distance == $signed({1'b1, {(CW-1){1'b0}}})
              || rsp_hit_distance == $signed({1'b0, {(CW-1){1'b1}}})))
      else $error("clamped distance is not a range bound");

   // Stalled result stays put while the receiver holds off.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_result)))
      else $error("waiting result changed before transfer");
`endif

endmodule

`default_nettype wire

@@ sim/ray_sphere_checker.sv @@
//------------------------------------------------------------------------------
// Ray-sphere intersection checker
// Watches the request and response queues of the intersection engine,
// predicts every result from the accepted ray-sphere pair and compares them.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_sphere_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_push,
   input  wire logic                                 req_full,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_origin_x,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_origin_y,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_origin_z,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_dir_x,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_dir_y,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_dir_z,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_center_x,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_center_y,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      req_center_z,
   input  wire logic [rsi_pkg::RADIUS_WIDTH-1:0]     req_sphere_radius,
   input  wire logic                                 rsp_empty,
   input  wire logic                                 rsp_pop,
   input  wire logic [1:0]                           rsp_status,
   input  wire logic [rsi_pkg::FIELD_WIDTH-1:0]      rsp_hit_distance,
   input  wire logic                                 rsp_saturated,
   output int                                        mismatches,
   output int                                        outstanding
);

   typedef logic signed [191:0] wide_type;

   localparam wide_type T_MAX = 192'sd2147483647;
   localparam wide_type T_MIN_MAG = 192'sd2147483648;

   rsi_pkg::result_type expected_results[$];

   // Nearer root of the ray-sphere quadratic, computed exactly in wide integers.
   function automatic rsi_pkg::result_type nearest_hit(
      input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
      input logic [31:0] dx, input logic [31:0] dy, input logic [31:0] dz,
      input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
      input logic [30:0] radius);
      rsi_pkg::result_type res;
      wide_type vx, vy, vz, wx, wy, wz, rr, a, h, c, disc, root, cand, num, mag, q, rem;
      logic negative;
      res = '0;
      if (dx == 0 && dy == 0 && dz == 0) begin
         res.status = rsi_pkg::STATUS_ZERO_DIR;
         return res;
      end
      vx = $signed(dx);
      vy = $signed(dy);
      vz = $signed(dz);
      wx = $signed(cx);
      wx = wx - $signed(ox);
      wy = $signed(cy);
      wy = wy - $signed(oy);
      wz = $signed(cz);
      wz = wz - $signed(oz);
      rr = {161'b0, radius};
      a = vx * vx + vy * vy + vz * vz;
      h = vx * wx + vy * wy + vz * wz;
      c = wx * wx + wy * wy + wz * wz - rr * rr;
      disc = h * h - a * c;
      if (disc < 0) begin
         res.status = rsi_pkg::STATUS_MISS;
         return res;
      end
      // Integer square root, one bit at a time from the top.
      root = 0;
      for (int b = 67; b >= 0; b--) begin
         cand = root | (192'sd1 <<< b);
         if (cand * cand <= disc) root = cand;
      end
      num = h - root;
      negative = num < 0;
      mag = negative ? -num : num;
      mag = mag <<< 16;
      q = mag / a;
      rem = mag % a;
      res.status = rsi_pkg::STATUS_HIT;
      if (negative) begin
         // Rounding toward minus infinity moves a negative quotient away from zero.
         if (rem != 0) q = q + 1;
         if (q > T_MIN_MAG) begin
            res.hit_distance = 32'h8000_0000;
            res.saturated = 1'b1;
         end else begin
            res.hit_distance = 32'(-q);
         end
      end else if (q > T_MAX) begin
         res.hit_distance = 32'h7FFF_FFFF;
         res.saturated = 1'b1;
      end else begin
         res.hit_distance = q[31:0];
      end
      return res;
   endfunction

   assign outstanding = expected_results.size();

   always @(posedge clock) begin
      rsi_pkg::result_type want;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req_push && !req_full) begin
            expected_results.push_back(nearest_hit(req_origin_x, req_origin_y, req_origin_z,
               req_dir_x, req_dir_y, req_dir_z, req_center_x, req_center_y, req_center_z,
               req_sphere_radius));
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with nothing expected: status %0d t %h sat %b",
                     $time, rsp_status, rsp_hit_distance, rsp_saturated);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status || rsp_hit_distance !== want.hit_distance ||
                   rsp_saturated !== want.saturated) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch: expected status %0d t %h sat %b, got %0d %h %b",
                        $time, want.status, want.hit_distance, want.saturated,
                        rsp_status, rsp_hit_distance, rsp_saturated);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

@@ sim/ray_sphere_intersect_tb.sv @@
//------------------------------------------------------------------------------
// Ray-sphere intersection testbench
// Drives ray-sphere pairs into the engine with random gaps and response
// stalls; a separate checker predicts and compares every result.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_sphere_intersect_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   logic [rsi_pkg::FIELD_WIDTH-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic [rsi_pkg::FIELD_WIDTH-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [rsi_pkg::FIELD_WIDTH-1:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [rsi_pkg::RADIUS_WIDTH-1:0] req_sphere_radius = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic [1:0] rsp_status;
   logic signed [rsi_pkg::FIELD_WIDTH-1:0] rsp_hit_distance;
   logic rsp_saturated;
   int mismatches;
   int outstanding;

   // Shared control between the sender and the receiver processes.
   logic steady_phase = 1'b0;   // no idling on either side while set
   logic hold_request = 1'b0;   // asks the receiver for one long hold-off

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ray_sphere_intersect dut (.*);

   ray_sphere_checker checker_inst (.*);

   // The receiver pops with random stalls. A hold-off request freezes it for a
   // long stretch so that the output queue and the pipeline fill and req_full
   // rises while the sender keeps offering pairs.
   always @(posedge clock) begin
      static int hold_count = 0;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_request && hold_count == 0) begin
         hold_count = 600;
         rsp_pop <= 1'b0;
      end else if (hold_count > 1) begin
         hold_count--;
         rsp_pop <= 1'b0;
      end else begin
         if (hold_count == 1) hold_count = 0;
         rsp_pop <= steady_phase || ($urandom_range(0, 99) >= 23);
      end
   end

   // A random coordinate of random magnitude, so that both tiny and huge
   // values appear and every bit is exercised.
   function automatic logic [31:0] scaled_coord(input int unsigned lo_shift);
      logic [31:0] raw;
      raw = $urandom;
      return $signed(raw) >>> $urandom_range(lo_shift, 31);
   endfunction

   // One transfer on the request queue. The push stays high into the next
   // pair unless the sender decides to idle afterwards; each idle cycle is
   // followed by another with the same chance.
   task automatic send_pair(input logic [31:0] ox, input logic [31:0] oy,
         input logic [31:0] oz, input logic [31:0] dx, input logic [31:0] dy,
         input logic [31:0] dz, input logic [31:0] cx, input logic [31:0] cy,
         input logic [31:0] cz, input logic [30:0] radius);
      req_origin_x <= ox;
      req_origin_y <= oy;
      req_origin_z <= oz;
      req_dir_x <= dx;
      req_dir_y <= dy;
      req_dir_z <= dz;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_sphere_radius <= radius;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      if (!steady_phase) begin
         while ($urandom_range(0, 99) < 23) begin
            req_push <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   // A pair whose direction points roughly at the sphere, so that most
   // of them hit and the square root and divider see real work.
   task automatic send_aimed_pair();
      logic [31:0] ox, oy, oz, cx, cy, cz, dx, dy, dz;
      int unsigned noise;
      ox = scaled_coord(8);
      oy = scaled_coord(8);
      oz = scaled_coord(8);
      cx = scaled_coord(8);
      cy = scaled_coord(8);
      cz = scaled_coord(8);
      noise = $urandom_range(10, 31);
      dx = (cx - ox) + ($signed($urandom) >>> noise);
      dy = (cy - oy) + ($signed($urandom) >>> noise);
      dz = (cz - oz) + ($signed($urandom) >>> $urandom_range(2, 31));
      send_pair(ox, oy, oz, dx, dy, dz, cx, cy, cz, 31'($urandom >> $urandom_range(1, 31)));
   endtask

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs. Unit is 32'h0001_0000 (1.0).
      // Zero direction vector, even with a sphere around the origin.
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h0001_0000);
      send_pair(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0,
         32'h8000_0000, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF);
      // Simple hit: origin at 0, sphere at z = 5 with radius 1, t = 4.
      send_pair(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0005_0000, 31'h0001_0000);
      // Origin inside the sphere gives a negative nearer root.
      send_pair(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_8000, 31'h0003_0000);
      // Clear miss, and a grazing ray with a zero discriminant.
      send_pair(0, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0005_0000, 0, 31'h0001_0000);
      send_pair(0, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0005_0000,
         31'h0001_0000);
      // Zero radius on the ray: a tangent point.
      send_pair(0, 0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 31'h0);
      // Tiny direction and a far sphere: positive clamp.
      send_pair(0, 0, 0, 0, 0, 1, 0, 0, 32'h7FFF_FFFF, 31'h0001_0000);
      // Tiny direction pointing away from a sphere around it: negative clamp.
      send_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 31'h7FFF_FFFF);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
         32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
         31'h7FFF_FFFF);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
         31'h0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
         31'h7FFF_FFFF);
      send_pair(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
         31'h7FFF_FFFF);
      // Only one direction component nonzero at its smallest step.
      send_pair(0, 0, 0, 0, 1, 0, 0, 32'h0000_0010, 0, 31'h0000_0008);

      // Random part: mostly aimed pairs, the rest unrestricted values.
      for (int n = 0; n < 800; n++) begin
         steady_phase <= (n >= 400 && n < 520);
         hold_request <= (n == 200);
         if ($urandom_range(0, 99) < 70)
            send_aimed_pair();
         else
            send_pair(scaled_coord(0), scaled_coord(0), scaled_coord(0), scaled_coord(0),
               scaled_coord(0), scaled_coord(0), scaled_coord(0), scaled_coord(0),
               scaled_coord(0), 31'($urandom >> $urandom_range(1, 31)));
      end
      req_push <= 1'b0;
      hold_request <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
